@@ sv/pwed_pkg.sv @@
package pwed_pkg;

  // Largest matrix the store holds.
  localparam int ROWS_MAX = 8;
  localparam int COLS_MAX = 64;

  // Index widths into the store; a row occupies a fixed stride of 2**COL_W.
  localparam int ROW_W = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
  localparam int COL_W = (COLS_MAX > 1) ? $clog2(COLS_MAX) : 1;
  localparam int ADDR_W = ROW_W + COL_W;
  localparam int STORE_DEPTH = 2 ** ADDR_W;

  // Field and register widths.
  localparam int SAMPLE_W = 16;
  localparam int ROW_CNT_W = 4;
  localparam int COL_CNT_W = 7;
  localparam int IDX_OUT_W = 3;
  localparam int ROOT_W = 20;
  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 7;
  localparam int OUT_DATA_W = 32;

  // Sum of squared differences and the square root datapath.
  localparam int DIFF_W = SAMPLE_W + 1;
  localparam int SQ_W = 2 * SAMPLE_W;
  localparam int SUM_W = SQ_W + COL_W;
  localparam int RAD_W = 2 * ROOT_W;
  localparam int REM_W = ROOT_W + 2;
  localparam int SQ_CNT_W = $clog2(ROOT_W);

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_PAIR,
    ST_MAC,
    ST_DRAIN,
    ST_ROOT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic clr;
    logic vld;
  } mac_ctrl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sqrt_stat_t;

endpackage

@@ sv/pairwise_euclidean_distance_core.sv @@
// Pairwise Euclidean distance matrix. Samples (signed Q3.12, in the low 16 bits
// of in_tdata) are loaded row-major, one per request and one per cycle, until
// row_count x column_count elements are in; row_count is clamped to 1..8 and
// column_count to 1..64. The block then stops taking input and emits all
// row_count * row_count entries of the distance matrix in row-major order, each
// the floor square root of the summed squared differences of two rows (Q.12
// units), with tlast on the final entry. Diagonal entries are zero; each other
// entry takes one multiply-accumulate per column through the shared squaring
// unit, fed from two copies of the sample store, then a short pipeline drain
// and the bit-serial square root unit. Emission stalls while out_tready is low.
// A write to either count register restarts loading with element (0,0); writes
// are meant to happen only while the block waits for samples. The store needs
// no clearing after reset, since a matrix is emitted only once fully written.
module pairwise_euclidean_distance_core
  import pwed_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  // Configuration write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // Sample input stream.
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [SAMPLE_W-1:0]   in_tdata,    // [15:0] sample
  // Distance output stream.
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,   // [2:0] row_index, [5:3] col_index,
                                             // [25:6] distance, [31:26] zero
  output logic                  out_tlast    // last entry of the matrix
);

  state_t               state_r, state_nxt;
  logic [ROW_CNT_W-1:0] row_count_r, row_count_nxt;
  logic [COL_CNT_W-1:0] column_count_r, column_count_nxt;
  logic [ROW_W-1:0]     ld_row_r, ld_row_nxt;
  logic [COL_W-1:0]     ld_col_r, ld_col_nxt;
  logic [ROW_W-1:0]     i_r, i_nxt;
  logic [ROW_W-1:0]     j_r, j_nxt;
  logic [COL_W-1:0]     k_r, k_nxt;
  logic [ROOT_W-1:0]    dist_r, dist_nxt;
  logic                 rd_v_r;

  logic [ROW_W-1:0]     rows_last;
  logic [COL_W-1:0]     cols_last;
  logic                 out_last;
  logic                 ram_we;
  logic                 issue;
  mac_ctrl_t            mac_ctl;
  logic                 mac_busy;
  logic [SUM_W-1:0]     mac_acc;
  logic                 sq_start;
  sqrt_stat_t           sq_stat;
  logic [ROOT_W-1:0]    sq_root;
  logic [SAMPLE_W-1:0]  rdata_a;
  logic [SAMPLE_W-1:0]  rdata_b;

  // Last row and column index in use, with out-of-range counts clamped.
  always_comb begin
    if (row_count_r == '0) begin
      rows_last = '0;
    end else if (32'(row_count_r) > ROWS_MAX) begin
      rows_last = ROW_W'(ROWS_MAX - 1);
    end else begin
      rows_last = ROW_W'(row_count_r - 1'b1);
    end
    if (column_count_r == '0) begin
      cols_last = '0;
    end else if (32'(column_count_r) > COLS_MAX) begin
      cols_last = COL_W'(COLS_MAX - 1);
    end else begin
      cols_last = COL_W'(column_count_r - 1'b1);
    end
  end

  assign out_last = (i_r == rows_last) && (j_r == rows_last);

  // Two copies of the store let one cycle read element k of both rows.
  pwed_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store_a (
    .clk  (clk),
    .we   (ram_we),
    .waddr({ld_row_r, ld_col_r}),
    .wdata(in_tdata),
    .raddr({i_r, k_r}),
    .rdata(rdata_a)
  );

  pwed_ram #(
    .WIDTH(SAMPLE_W),
    .DEPTH(STORE_DEPTH)
  ) u_store_b (
    .clk  (clk),
    .we   (ram_we),
    .waddr({ld_row_r, ld_col_r}),
    .wdata(in_tdata),
    .raddr({j_r, k_r}),
    .rdata(rdata_b)
  );

  pwed_mac u_mac (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (mac_ctl),
    .a    (rdata_a),
    .b    (rdata_b),
    .acc  (mac_acc),
    .busy (mac_busy)
  );

  pwed_isqrt u_isqrt (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (sq_start),
    .radicand(mac_acc),
    .root    (sq_root),
    .stat    (sq_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_LOAD;
      row_count_r <= ROW_CNT_W'(ROWS_MAX);
      column_count_r <= COL_CNT_W'(COLS_MAX);
      ld_row_r <= '0;
      ld_col_r <= '0;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      rd_v_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      row_count_r <= row_count_nxt;
      column_count_r <= column_count_nxt;
      ld_row_r <= ld_row_nxt;
      ld_col_r <= ld_col_nxt;
      i_r <= i_nxt;
      j_r <= j_nxt;
      k_r <= k_nxt;
      rd_v_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    dist_r <= dist_nxt;
  end

  // Sequencer: load, then per (row, column) pair clear the accumulator and, off
  // the diagonal, sum the columns' squares and take the root; present the entry.
  always_comb begin
    state_nxt = state_r;
    row_count_nxt = row_count_r;
    column_count_nxt = column_count_r;
    ld_row_nxt = ld_row_r;
    ld_col_nxt = ld_col_r;
    i_nxt = i_r;
    j_nxt = j_r;
    k_nxt = k_r;
    dist_nxt = dist_r;
    in_tready = 1'b0;
    out_tvalid = 1'b0;
    ram_we = 1'b0;
    issue = 1'b0;
    mac_ctl = '0;
    sq_start = 1'b0;

    case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ram_we = 1'b1;
          if (ld_col_r == cols_last) begin
            ld_col_nxt = '0;
            if (ld_row_r == rows_last) begin
              ld_row_nxt = '0;
              i_nxt = '0;
              j_nxt = '0;
              state_nxt = ST_PAIR;
            end else begin
              ld_row_nxt = ld_row_r + 1'b1;
            end
          end else begin
            ld_col_nxt = ld_col_r + 1'b1;
          end
        end
      end
      ST_PAIR: begin
        mac_ctl.clr = 1'b1;
        k_nxt = '0;
        if (i_r == j_r) begin
          dist_nxt = '0;
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        issue = 1'b1;
        k_nxt = k_r + 1'b1;
        if (k_r == cols_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // Wait until the last read and its square have reached the sum.
        if (!rd_v_r && !mac_busy) begin
          sq_start = 1'b1;
          state_nxt = ST_ROOT;
        end
      end
      ST_ROOT: begin
        if (sq_stat.done) begin
          dist_nxt = sq_root;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (out_last) begin
            state_nxt = ST_LOAD;
          end else begin
            if (j_r == rows_last) begin
              j_nxt = '0;
              i_nxt = i_r + 1'b1;
            end else begin
              j_nxt = j_r + 1'b1;
            end
            state_nxt = ST_PAIR;
          end
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // A write to the row or column count register restarts loading of the matrix.
    if (cfg_valid) begin
      if (cfg_index == CFG_ROW_COUNT) begin
        row_count_nxt = cfg_data[ROW_CNT_W-1:0];
        ld_row_nxt = '0;
        ld_col_nxt = '0;
      end else if (cfg_index == CFG_COLUMN_COUNT) begin
        column_count_nxt = cfg_data[COL_CNT_W-1:0];
        ld_row_nxt = '0;
        ld_col_nxt = '0;
      end
    end

    mac_ctl.vld = rd_v_r;
  end

  assign cfg_ready = 1'b1;
  assign out_tdata = {(OUT_DATA_W - 2 * IDX_OUT_W - ROOT_W)'(0), dist_r,
                      IDX_OUT_W'(j_r), IDX_OUT_W'(i_r)};
  assign out_tlast = out_last;

  // Loading and emission never overlap.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while a result is presented");

  // The root unit is started only when idle.
  a_sqrt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    sq_start |-> !sq_stat.busy)
    else $error("square root started while busy");

  // The final entry hands the block back to loading.
  a_last_reload: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("not ready for samples after the last entry");

  // The accumulator is fed only while summing a pair.
  a_mac_window: assert property (@(posedge clk) disable iff (!rst_n)
    issue |-> (i_r != j_r))
    else $error("store read issued for a diagonal entry");

endmodule

@@ sv/pwed_ram.sv @@
module pwed_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ sv/pwed_mac.sv @@
module pwed_mac
  import pwed_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ctrl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] a,
  input  logic signed [SAMPLE_W-1:0] b,
  output logic [SUM_W-1:0]           acc,
  output logic                       busy
);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [2*DIFF_W-1:0] prod;
  logic [SQ_W-1:0]            sq_r;
  logic                       sq_v_r;
  logic [SUM_W-1:0]           acc_r;

  // The square of a difference of two 16-bit values always fits 32 bits.
  assign diff = DIFF_W'(a) - DIFF_W'(b);
  assign prod = diff * diff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r <= 1'b0;
    end else begin
      sq_v_r <= ctl.vld;
    end
  end

  always_ff @(posedge clk) begin
    sq_r <= prod[SQ_W-1:0];
    if (ctl.clr) begin
      acc_r <= '0;
    end else if (sq_v_r) begin
      acc_r <= acc_r + SUM_W'(sq_r);
    end
  end

  assign acc = acc_r;
  assign busy = sq_v_r;

endmodule

@@ sv/pwed_isqrt.sv @@
module pwed_isqrt
  import pwed_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [SUM_W-1:0]  radicand,
  output logic [ROOT_W-1:0] root,
  output sqrt_stat_t        stat
);

  logic [RAD_W-1:0]    rad_r;
  logic [REM_W-1:0]    rem_r;
  logic [ROOT_W-1:0]   root_r;
  logic [SQ_CNT_W-1:0] cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [REM_W-1:0]    rem_pre;
  logic [REM_W-1:0]    trial;
  logic                take;

  // One result bit per cycle: bring down two radicand bits and try 4*root+1.
  assign rem_pre = {rem_r[REM_W-3:0], rad_r[RAD_W-1 -: 2]};
  assign trial = {root_r, 2'b01};
  assign take = (rem_pre >= trial);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= SQ_CNT_W'(ROOT_W - 1);
      end else if (busy_r) begin
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r <= RAD_W'(radicand);
      rem_r <= '0;
      root_r <= '0;
    end else if (busy_r) begin
      rad_r <= {rad_r[RAD_W-3:0], 2'b00};
      rem_r <= take ? (rem_pre - trial) : rem_pre;
      root_r <= {root_r[ROOT_W-2:0], take};
    end
  end

  assign root = root_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

endmodule
